// ===== rtl/bcpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared constants, types and helpers of the Bezier curve point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpe_pkg;

  // default for the largest number of control points
  localparam int unsigned MAX_POINTS_DEF = 7;

  // coordinate and parameter formats
  localparam int unsigned COORD_W = 32;
  localparam int unsigned LANES   = 2;
  localparam int unsigned CP_W    = LANES * COORD_W;
  localparam int unsigned T_W     = 17;
  localparam int unsigned FRAC_W  = 16;
  localparam logic [T_W-1:0] T_ONE = 17'd65536;

  // limb multiply-accumulate widths
  localparam int unsigned PROD_W  = T_W + COORD_W;
  localparam int unsigned MAC_W   = PROD_W + 1;
  localparam int unsigned CARRY_W = MAC_W - COORD_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PC_W       = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CP_BASE     = 3'd1;
  localparam logic [PC_W-1:0]      POINT_COUNT_RST = 3'd3;

  // command field widths, sized for the largest supported point count
  localparam int unsigned IDX_MAX_W  = 3;
  localparam int unsigned LIMB_MAX_W = 2;

  // number of 32-bit limbs that hold the widest de Casteljau value
  function automatic int unsigned limb_count(input int unsigned max_points);
    limb_count = (FRAC_W * max_points + FRAC_W + COORD_W - 1) / COORD_W;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND
  } state_e;

  typedef struct packed {
    logic                  load_t;
    logic                  fetch;
    logic                  issue;
    logic                  src_cp;
    logic [IDX_MAX_W-1:0]  idx;
    logic [LIMB_MAX_W-1:0] limb;
    logic [IDX_MAX_W-1:0]  n;
    logic                  out_load;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bezier_curve_point_eval.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_point_eval
// Bezier curve point evaluator, Bernstein form, exact fixed point.
// ----------------------------------------------------------------------------
// Evaluates one point of a Bezier curve per transfer on the input channel:
// t_value_i is unsigned Q1.16 (values above 1.0 saturate to 1.0) and the
// result on point_x_o/point_y_o is signed Q16.16, rounded to nearest with
// ties toward plus infinity. The curve uses point_count control points
// (register 0; zero acts as one, values above MAX_POINTS clamp); control
// points live in registers 1 to 7, x in bits 31:0 and y in bits 63:32.
// The weighted sum is built exactly by de Casteljau's recurrence in integer
// form, one 32-bit limb of x and y per cycle on a shared pair of 17x32
// multiply-accumulate lanes, so nothing is lost before the final rounding.
// Intermediate values span four 32-bit limbs at MAX_POINTS = 7. One item
// is in flight at a time; the next one is taken in the cycle after the
// result is loaded into the output register, even if that result still
// waits for out_ready_i. Configuration writes take effect at once and are
// expected only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_curve_point_eval #(
  parameter int unsigned MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [bcpe_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bcpe_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // curve parameter channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bcpe_pkg::T_W-1:0]             t_value_i,
  // curve point channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [bcpe_pkg::COORD_W-1:0]  point_x_o,
  output logic signed [bcpe_pkg::COORD_W-1:0]  point_y_o
);

  // command bundle from the sequencer to the datapath
  bcpe_pkg::cmd_t cmd;

  // sequencer: holds point_count, steps level / operation / limb counters,
  // owns both handshakes and the output valid flag
  bcpe_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_pc_i    (cfg_data_i[bcpe_pkg::PC_W-1:0]),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath: control point store, intermediate store, two multiply-
  // accumulate lanes (x and y), rounding shifter and output register
  bcpe_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .t_value_i  (t_value_i),
    .cmd_i      (cmd),
    .point_x_o  (point_x_o),
    .point_y_o  (point_y_o)
  );

endmodule

`default_nettype wire

// ===== rtl/bcpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcpe_ctrl
// Sequencer: walks levels, operations and limbs of the de Casteljau pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_ctrl #(
  parameter int unsigned MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcpe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bcpe_pkg::PC_W-1:0]      cfg_pc_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bcpe_pkg::cmd_t                 cmd_o
);

  localparam int unsigned NUM_LIMBS = bcpe_pkg::limb_count(MAX_POINTS);
  localparam int unsigned IDX_W     = $clog2(MAX_POINTS);
  localparam int unsigned LIMB_W    = $clog2(NUM_LIMBS);
  localparam int unsigned PC_W      = bcpe_pkg::PC_W;

  bcpe_pkg::state_e    state_q, state_d;
  logic [PC_W-1:0]     pc_q;
  logic [PC_W-1:0]     cnt;
  logic [IDX_W-1:0]    n;
  logic [IDX_W-1:0]    level_q, level_d;
  logic [IDX_W-1:0]    op_q, op_d;
  logic [LIMB_W-1:0]   limb_q, limb_d;
  logic                out_valid_q, out_valid_d;

  // point count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bcpe_pkg::POINT_COUNT_RST;
    end else if (cfg_we_i && cfg_idx_i == bcpe_pkg::REG_POINT_COUNT) begin
      pc_q <= cfg_pc_i;
    end
  end

  // zero counts as one point, counts above the limit are clamped
  always_comb begin
    if (pc_q == '0) begin
      cnt = PC_W'(1);
    end else if (pc_q > PC_W'(MAX_POINTS)) begin
      cnt = PC_W'(MAX_POINTS);
    end else begin
      cnt = pc_q;
    end
    n = IDX_W'(cnt - PC_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcpe_pkg::ST_IDLE;
      level_q     <= '0;
      op_q        <= '0;
      limb_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      op_q        <= op_d;
      limb_q      <= limb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    op_d        = op_q;
    limb_d      = limb_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;

    cmd_o          = '0;
    cmd_o.n        = bcpe_pkg::IDX_MAX_W'(n);
    cmd_o.idx      = bcpe_pkg::IDX_MAX_W'(op_q);
    cmd_o.limb     = bcpe_pkg::LIMB_MAX_W'(limb_q);
    cmd_o.src_cp   = (level_q == IDX_W'(1));

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bcpe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_t = 1'b1;
          level_d      = IDX_W'(1);
          op_d         = '0;
          limb_d       = '0;
          state_d      = (n == '0) ? bcpe_pkg::ST_FETCH : bcpe_pkg::ST_RUN;
        end
      end
      bcpe_pkg::ST_FETCH: begin
        // single point: fetch control point 0 for a straight copy
        cmd_o.fetch = 1'b1;
        cmd_o.idx   = '0;
        state_d     = bcpe_pkg::ST_ROUND;
      end
      bcpe_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (limb_q == LIMB_W'(NUM_LIMBS - 1)) begin
          limb_d = '0;
          if (op_q == n - level_q) begin
            op_d = '0;
            if (level_q == n) begin
              state_d = bcpe_pkg::ST_DRAIN;
            end else begin
              level_d = level_q + IDX_W'(1);
            end
          end else begin
            op_d = op_q + IDX_W'(1);
          end
        end else begin
          limb_d = limb_q + LIMB_W'(1);
        end
      end
      bcpe_pkg::ST_DRAIN: begin
        state_d = bcpe_pkg::ST_ROUND;
      end
      bcpe_pkg::ST_ROUND: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = bcpe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bcpe_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/bcpe_dpath.sv =====
// ----------------------------------------------------------------------------
// bcpe_dpath
// Control point store, limb-serial de Casteljau datapath and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_dpath #(
  parameter int unsigned MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bcpe_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [bcpe_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [bcpe_pkg::T_W-1:0]               t_value_i,
  input  bcpe_pkg::cmd_t                         cmd_i,
  output logic signed [bcpe_pkg::COORD_W-1:0]    point_x_o,
  output logic signed [bcpe_pkg::COORD_W-1:0]    point_y_o
);

  localparam int unsigned COORD_W   = bcpe_pkg::COORD_W;
  localparam int unsigned LANES     = bcpe_pkg::LANES;
  localparam int unsigned CP_W      = bcpe_pkg::CP_W;
  localparam int unsigned T_W       = bcpe_pkg::T_W;
  localparam int unsigned PROD_W    = bcpe_pkg::PROD_W;
  localparam int unsigned MAC_W     = bcpe_pkg::MAC_W;
  localparam int unsigned CARRY_W   = bcpe_pkg::CARRY_W;
  localparam int unsigned CFG_IDX_W = bcpe_pkg::CFG_IDX_W;
  localparam int unsigned NUM_LIMBS = bcpe_pkg::limb_count(MAX_POINTS);
  localparam int unsigned IDX_W     = $clog2(MAX_POINTS);
  localparam int unsigned LIMB_W    = $clog2(NUM_LIMBS);
  localparam int unsigned WA_W      = IDX_W + LIMB_W;
  localparam int unsigned WM_DEPTH  = MAX_POINTS * (2 ** LIMB_W);
  localparam int unsigned ACC_W     = NUM_LIMBS * COORD_W;
  localparam int unsigned SH_W      = $clog2(ACC_W);

  // curve parameter
  logic [T_W-1:0] t_sat;
  logic [T_W-1:0] t_q, u_q;

  assign t_sat = (t_value_i > bcpe_pkg::T_ONE) ? bcpe_pkg::T_ONE : t_value_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_t) begin
      t_q <= t_sat;
      u_q <= bcpe_pkg::T_ONE - t_sat;
    end
  end

  // control point store, entries read as zero until written
  logic [CP_W-1:0]       cp_mem [MAX_POINTS];
  logic [MAX_POINTS-1:0] cp_vld_q;
  logic                  cp_we, cp_re;
  logic [IDX_W-1:0]      cp_wa, cp_ra, cp_rb;
  logic [CP_W-1:0]       cp_a_q, cp_b_q;
  logic                  cp_a_vld_q, cp_b_vld_q;
  logic [CP_W-1:0]       cp_a, cp_b;

  assign cp_we = cfg_we_i && (cfg_idx_i >= bcpe_pkg::REG_CP_BASE)
                 && ((cfg_idx_i - bcpe_pkg::REG_CP_BASE) < CFG_IDX_W'(MAX_POINTS));
  assign cp_wa = IDX_W'(cfg_idx_i - bcpe_pkg::REG_CP_BASE);
  assign cp_re = cmd_i.fetch || (cmd_i.issue && cmd_i.src_cp);
  assign cp_ra = cmd_i.idx[IDX_W-1:0];
  assign cp_rb = cp_ra + IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (cp_we) begin
      cp_mem[cp_wa] <= cfg_data_i;
    end
    if (cp_re) begin
      cp_a_q <= cp_mem[cp_ra];
      cp_b_q <= cp_mem[cp_rb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_vld_q   <= '0;
      cp_a_vld_q <= 1'b0;
      cp_b_vld_q <= 1'b0;
    end else begin
      if (cp_we) begin
        cp_vld_q[cp_wa] <= 1'b1;
      end
      if (cp_re) begin
        cp_a_vld_q <= cp_vld_q[cp_ra];
        cp_b_vld_q <= cp_vld_q[cp_rb];
      end
    end
  end

  assign cp_a = cp_a_vld_q ? cp_a_q : '0;
  assign cp_b = cp_b_vld_q ? cp_b_q : '0;

  // intermediate value store, one limb of both lanes per entry
  logic [CP_W-1:0]   work_mem [WM_DEPTH];
  logic [WA_W-1:0]   wm_ra, wm_rb, wm_wa;
  logic [CP_W-1:0]   wa_q, wb_q;
  logic [CP_W-1:0]   wm_wdata;

  assign wm_ra = {cp_ra, cmd_i.limb[LIMB_W-1:0]};
  assign wm_rb = {cp_rb, cmd_i.limb[LIMB_W-1:0]};

  // second stage: operands are back from the stores
  logic              s2_vld_q;
  logic              s2_src_cp_q;
  logic [IDX_W-1:0]  s2_idx_q;
  logic [LIMB_W-1:0] s2_limb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s2_src_cp_q <= cmd_i.src_cp;
      s2_idx_q    <= cp_ra;
      s2_limb_q   <= cmd_i.limb[LIMB_W-1:0];
    end
  end

  assign wm_wa = {s2_idx_q, s2_limb_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      wa_q <= work_mem[wm_ra];
      wb_q <= work_mem[wm_rb];
    end
    if (s2_vld_q) begin
      work_mem[wm_wa] <= wm_wdata;
    end
  end

  // limb multiply-accumulate: u*a + t*b + carry
  logic [COORD_W-1:0]                 cpa_lane [LANES];
  logic [COORD_W-1:0]                 cpb_lane [LANES];
  logic [COORD_W-1:0]                 opa [LANES];
  logic [COORD_W-1:0]                 opb [LANES];
  logic [PROD_W-1:0]                  prod_a [LANES];
  logic [PROD_W-1:0]                  prod_b [LANES];
  logic [CARRY_W-1:0]                 cin [LANES];
  logic [MAC_W-1:0]                   mac [LANES];
  logic [CARRY_W-1:0]                 carry_q [LANES];
  logic [NUM_LIMBS-1:0][COORD_W-1:0]  acc_q [LANES];

  always_comb begin
    wm_wdata = '0;
    for (int l = 0; l < LANES; l++) begin
      cpa_lane[l] = cp_a[l*COORD_W +: COORD_W];
      cpb_lane[l] = cp_b[l*COORD_W +: COORD_W];
      if (s2_src_cp_q) begin
        // first level: sign-extended control points
        opa[l] = (s2_limb_q == '0) ? cpa_lane[l] : {COORD_W{cpa_lane[l][COORD_W-1]}};
        opb[l] = (s2_limb_q == '0) ? cpb_lane[l] : {COORD_W{cpb_lane[l][COORD_W-1]}};
      end else begin
        opa[l] = wa_q[l*COORD_W +: COORD_W];
        opb[l] = wb_q[l*COORD_W +: COORD_W];
      end
      prod_a[l] = u_q * opa[l];
      prod_b[l] = t_q * opb[l];
      cin[l]    = (s2_limb_q == '0) ? '0 : carry_q[l];
      mac[l]    = MAC_W'(prod_a[l]) + MAC_W'(prod_b[l]) + MAC_W'(cin[l]);
      wm_wdata[l*COORD_W +: COORD_W] = mac[l][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      for (int l = 0; l < LANES; l++) begin
        carry_q[l]           <= mac[l][MAC_W-1:COORD_W];
        acc_q[l][s2_limb_q]  <= mac[l][COORD_W-1:0];
      end
    end
  end

  // round to nearest and drop the 16*n fraction bits
  logic [SH_W-1:0]    sh;
  logic [ACC_W-1:0]   half;
  logic [ACC_W-1:0]   rsum [LANES];
  logic [ACC_W-1:0]   rshift [LANES];
  logic [COORD_W-1:0] res [LANES];
  logic [COORD_W-1:0] out_x_q, out_y_q;

  always_comb begin
    sh   = SH_W'(cmd_i.n * bcpe_pkg::FRAC_W);
    half = (cmd_i.n == '0) ? '0 : (ACC_W'(1) << (sh - SH_W'(1)));
    for (int l = 0; l < LANES; l++) begin
      rsum[l]   = acc_q[l] + half;
      rshift[l] = rsum[l] >> sh;
      res[l]    = (cmd_i.n == '0) ? cpa_lane[l] : rshift[l][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_q <= res[0];
      out_y_q <= res[1];
    end
  end

  assign point_x_o = out_x_q;
  assign point_y_o = out_y_q;

endmodule

`default_nettype wire

// ===== rtl/bcpe_chk.sv =====
// ----------------------------------------------------------------------------
// bcpe_chk
// Port-level assertions for the Bezier curve point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bcpe_pkg::COORD_W-1:0]  point_x_o,
  input logic [bcpe_pkg::COORD_W-1:0]  point_y_o
);

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(point_x_o) && $stable(point_y_o))
    else $error("result changed while stalled");

  // one item in flight: no second transfer right after an input transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // a new result is loaded only while the input side is closed
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a busy phase");

  // no result in the cycle right after an input transfer
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result faster than the minimum latency");

endmodule

bind bezier_curve_point_eval bcpe_chk u_bcpe_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .point_x_o   (point_x_o),
  .point_y_o   (point_y_o)
);

`default_nettype wire
